/* hdl/srrt_pkg.sv */
// ----------------------------------------------------------------------------
// srrt_pkg
// Shared types and constants for the request retransmission timer: timer
// width, request and event codes, configuration register indexes and resets.
// ----------------------------------------------------------------------------
package srrt_pkg;

    // Width of the millisecond timers.
    localparam int TIME_BITS = 24;

    // Widths of the configuration registers and of the configuration port.
    localparam int FIRST_BITS    = 16;
    localparam int LIMIT_BITS    = 24;
    localparam int ATTEMPT_BITS  = 4;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_IDX_BITS  = 2;

    // Register values after reset.
    localparam logic [FIRST_BITS-1:0]   FIRST_TIMEOUT_RESET = FIRST_BITS'(500);
    localparam logic [LIMIT_BITS-1:0]   MAX_REQUEST_RESET   = LIMIT_BITS'(39500);
    localparam logic [ATTEMPT_BITS-1:0] MAX_ATTEMPTS_RESET  = ATTEMPT_BITS'(6);

    // Largest value a timer can hold.
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [ATTEMPT_BITS-1:0] attempt_t;

    // Kind of an incoming transaction.
    typedef enum logic [1:0] {
        REQ_START    = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_RESPONSE = 2'd2,
        REQ_CANCEL   = 2'd3
    } req_type_t;

    // Event reported with each result.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SEND    = 3'd1,
        EV_TIMEOUT = 3'd2,
        EV_DONE    = 3'd3,
        EV_IGNORED = 3'd4
    } event_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FIRST_TIMEOUT = 2'd0,
        CFG_MAX_REQUEST   = 2'd1,
        CFG_MAX_ATTEMPTS  = 2'd2
    } cfg_index_t;

endpackage

/* hdl/srrt_if.sv */
// ----------------------------------------------------------------------------
// srrt_if
// Valid/ready channels of the retransmission timer: the command channel
// that carries requests and the result channel that carries events.
// ----------------------------------------------------------------------------
interface srrt_cmd_if;
    logic                  valid;
    logic                  ready;
    srrt_pkg::req_type_t   req_type;
    logic                  response_ok;

    modport source (output valid, output req_type, output response_ok, input ready);
    modport sink   (input valid, input req_type, input response_ok, output ready);
endinterface

interface srrt_res_if;
    logic                  valid;
    logic                  ready;
    srrt_pkg::event_t      event_res;
    srrt_pkg::attempt_t    try_number;
    logic                  busy_res;

    modport source (output valid, output event_res, output try_number, output busy_res,
                    input ready);
    modport sink   (input valid, input event_res, input try_number, input busy_res,
                    output ready);
endinterface

/* hdl/stun_request_retransmit_timer_top.sv */
// ----------------------------------------------------------------------------
// stun_request_retransmit_timer_top
// Retransmission timer for one outstanding request.
//
// The cmd channel carries start, one-millisecond tick, response and cancel
// transactions. Every accepted transaction yields exactly one transaction on
// the res channel: the event (send, timeout, done, ignored or nothing), the
// try count after it and whether a request is still outstanding.
// A command is captured in an input register; it is then evaluated
// against the timer state in one pass, and the result register is loaded
// with the outcome and presents it on res. One command per cycle is
// sustained while res is ready; the state update in that single pass is
// what bounds the rate.
// When res stalls, the result register holds and the input register still
// takes one more command; cmd.ready falls only once both are full.
// Configuration writes go through cfg_we/cfg_index/cfg_wdata. The user must
// make them only while the block is idle; the block does not enforce this.
// Reset: registers 500 ms, 39500 ms and 6 tries; timer idle, all counts zero.
// ----------------------------------------------------------------------------
module stun_request_retransmit_timer_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    srrt_cmd_if.sink                             cmd,
    srrt_res_if.source                           res,
    input  logic                                 cfg_we,
    input  logic [srrt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [srrt_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import srrt_pkg::*;

    // Configuration registers.
    logic [FIRST_BITS-1:0] first_timeout_reg;
    logic [LIMIT_BITS-1:0] max_request_reg;
    attempt_t              max_attempts_reg;

    // Timer state.
    logic     active_reg, active_next;
    logic     armed_reg, armed_next;
    attempt_t attempt_reg, attempt_next;
    time_t    timeout_reg, timeout_next;
    time_t    countdown_reg, countdown_next;
    time_t    elapsed_reg, elapsed_next;

    // Input stage.
    logic      in_valid_reg;
    req_type_t in_type_reg;
    logic      in_ok_reg;

    // Result stage.
    logic     out_valid_reg;
    event_t   event_reg, event_next;
    attempt_t try_reg;
    logic     busy_reg;

    logic advance;

    // Working values for the tick path.
    time_t                limit;
    time_t                elapsed_inc;
    attempt_t             attempt_inc;
    logic [TIME_BITS+1:0] timeout_grow;
    time_t                timeout_sat;

    // The input stage moves on when the result register is free or drained.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || advance;

    // Configuration register writes; unused indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_timeout_reg <= FIRST_TIMEOUT_RESET;
            max_request_reg   <= MAX_REQUEST_RESET;
            max_attempts_reg  <= MAX_ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST_TIMEOUT: first_timeout_reg <= cfg_wdata[FIRST_BITS-1:0];
                CFG_MAX_REQUEST:   max_request_reg   <= cfg_wdata[LIMIT_BITS-1:0];
                CFG_MAX_ATTEMPTS:  max_attempts_reg  <= cfg_wdata[ATTEMPT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Saturated arithmetic used by the tick path.
    always_comb
    begin
        limit        = max_request_reg;
        elapsed_inc  = (elapsed_reg == TIME_MAX) ? TIME_MAX : elapsed_reg + 1'b1;
        attempt_inc  = (attempt_reg == {ATTEMPT_BITS{1'b1}}) ? attempt_reg
                                                              : attempt_reg + 1'b1;
        timeout_grow = {1'b0, timeout_reg, 1'b0}
                     + (TIME_BITS+2)'(first_timeout_reg);
        timeout_sat  = (timeout_grow > (TIME_BITS+2)'(TIME_MAX))
                     ? TIME_MAX : timeout_grow[TIME_BITS-1:0];
    end

    // Next state and event for the command in the input register.
    always_comb
    begin
        active_next    = active_reg;
        armed_next     = armed_reg;
        attempt_next   = attempt_reg;
        timeout_next   = timeout_reg;
        countdown_next = countdown_reg;
        elapsed_next   = elapsed_reg;
        event_next     = EV_NONE;

        case (in_type_reg)
            REQ_START:
            begin
                active_next    = 1'b1;
                armed_next     = 1'b1;
                attempt_next   = '0;
                timeout_next   = TIME_BITS'(first_timeout_reg);
                countdown_next = TIME_BITS'(first_timeout_reg);
                elapsed_next   = '0;
                event_next     = EV_SEND;
            end
            REQ_TICK:
            begin
                if (active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= limit)
                    begin
                        // The overall limit wins over the retransmit countdown.
                        active_next = 1'b0;
                        armed_next  = 1'b0;
                        event_next  = EV_TIMEOUT;
                    end
                    else if (armed_reg)
                    begin
                        if (countdown_reg > TIME_BITS'(1))
                        begin
                            countdown_next = countdown_reg - 1'b1;
                        end
                        else
                        begin
                            // Countdown expired: count the try, then resend or stop.
                            countdown_next = '0;
                            armed_next     = 1'b0;
                            attempt_next   = attempt_inc;
                            if (!(attempt_inc >= max_attempts_reg || elapsed_inc > limit))
                            begin
                                timeout_next   = timeout_sat;
                                countdown_next = timeout_sat;
                                armed_next     = 1'b1;
                                event_next     = EV_SEND;
                            end
                        end
                    end
                end
            end
            REQ_RESPONSE:
            begin
                if (active_reg && in_ok_reg)
                begin
                    active_next = 1'b0;
                    armed_next  = 1'b0;
                    event_next  = EV_DONE;
                end
                else
                begin
                    event_next = EV_IGNORED;
                end
            end
            default:
            begin
                active_next = 1'b0;
                armed_next  = 1'b0;
            end
        endcase
    end

    // Control registers: input and result valid flags and timer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            active_reg    <= 1'b0;
            armed_reg     <= 1'b0;
            attempt_reg   <= '0;
            timeout_reg   <= '0;
            countdown_reg <= '0;
            elapsed_reg   <= '0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                active_reg    <= active_next;
                armed_reg     <= armed_next;
                attempt_reg   <= attempt_next;
                timeout_reg   <= timeout_next;
                countdown_reg <= countdown_next;
                elapsed_reg   <= elapsed_next;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the input and result stages.
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            in_type_reg <= cmd.req_type;
            in_ok_reg   <= cmd.response_ok;
        end
        if (advance)
        begin
            event_reg <= event_next;
            try_reg   <= attempt_next;
            busy_reg  <= active_next;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.event_res  = event_reg;
    assign res.try_number = try_reg;
    assign res.busy_res   = busy_reg;

endmodule
